[design/agfe_pkg.sv]
// agfe_pkg: shared types, constants and microcode for the gain fade envelope
// holds transaction payloads, control word layout, program rom and entry table
// depends on nothing
package agfe_pkg;

  // default widths of the gain and time datapath
  localparam int unsigned GAIN_BITS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF = 40;

  // fraction bits of the interpolation ratio
  localparam int unsigned RATIO_BITS = 16;

  // program counter width
  localparam int unsigned PC_W = 4;

  typedef logic [PC_W-1:0] pc_t;

  // action codes of an input transaction
  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_SET      = 3'd1,
    ACT_FADE_TO  = 3'd2,
    ACT_FADE_OUT = 3'd3,
    ACT_LOAD     = 3'd4
  } action_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_BEGIN,
    OP_CHECK,
    OP_DIV,
    OP_MUL,
    OP_APPLY,
    OP_FINISH,
    OP_SET,
    OP_FADE_TO,
    OP_FADE_OUT,
    OP_LOAD
  } op_e;

  // sequencing of a control word
  typedef enum logic [1:0] {
    BR_NEXT,
    BR_SKIP,
    BR_LOOP,
    BR_END
  } br_e;

  typedef struct packed {
    op_e  op;
    logic slot;
    br_e  br;
    pc_t  target;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic skip;
    logic div_last;
  } status_t;

  // input transaction payload
  typedef struct packed {
    logic [2:0]  action;
    logic [23:0] elapsed_us;
    logic [15:0] gain_value;
    logic [31:0] duration_us;
    logic        fade_now;
    logic [39:0] total_us;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic [15:0] current_gain;
    logic [15:0] target_gain;
    logic        fading;
  } out_item_t;

  // program entry points
  localparam pc_t PC_TICK     = pc_t'(0);
  localparam pc_t PC_SLOT1    = pc_t'(5);
  localparam pc_t PC_FINISH   = pc_t'(9);
  localparam pc_t PC_SET      = pc_t'(10);
  localparam pc_t PC_FADE_TO  = pc_t'(11);
  localparam pc_t PC_FADE_OUT = pc_t'(12);
  localparam pc_t PC_LOAD     = pc_t'(13);
  localparam pc_t PC_IGNORE   = pc_t'(14);

  function automatic ctrl_t cw(op_e op, logic slot, br_e br, pc_t target);
    ctrl_t c;
    c.op     = op;
    c.slot   = slot;
    c.br     = br;
    c.target = target;
    return c;
  endfunction

  // microcode program
  function automatic ctrl_t rom_word(pc_t pc);
    ctrl_t c;
    unique case (pc)
      pc_t'(0):  c = cw(OP_BEGIN,    1'b0, BR_NEXT, PC_TICK);
      pc_t'(1):  c = cw(OP_CHECK,    1'b0, BR_SKIP, PC_SLOT1);
      pc_t'(2):  c = cw(OP_DIV,      1'b0, BR_LOOP, PC_TICK);
      pc_t'(3):  c = cw(OP_MUL,      1'b0, BR_NEXT, PC_TICK);
      pc_t'(4):  c = cw(OP_APPLY,    1'b0, BR_NEXT, PC_TICK);
      pc_t'(5):  c = cw(OP_CHECK,    1'b1, BR_SKIP, PC_FINISH);
      pc_t'(6):  c = cw(OP_DIV,      1'b1, BR_LOOP, PC_TICK);
      pc_t'(7):  c = cw(OP_MUL,      1'b1, BR_NEXT, PC_TICK);
      pc_t'(8):  c = cw(OP_APPLY,    1'b1, BR_NEXT, PC_TICK);
      pc_t'(9):  c = cw(OP_FINISH,   1'b0, BR_END,  PC_TICK);
      pc_t'(10): c = cw(OP_SET,      1'b0, BR_END,  PC_TICK);
      pc_t'(11): c = cw(OP_FADE_TO,  1'b0, BR_END,  PC_TICK);
      pc_t'(12): c = cw(OP_FADE_OUT, 1'b1, BR_END,  PC_TICK);
      pc_t'(13): c = cw(OP_LOAD,     1'b0, BR_END,  PC_TICK);
      default:   c = cw(OP_NOP,      1'b0, BR_END,  PC_TICK);
    endcase
    return c;
  endfunction

  // first step for each action
  function automatic pc_t entry_pc(logic [2:0] action);
    pc_t p;
    unique case (action)
      ACT_TICK:     p = PC_TICK;
      ACT_SET:      p = PC_SET;
      ACT_FADE_TO:  p = PC_FADE_TO;
      ACT_FADE_OUT: p = PC_FADE_OUT;
      ACT_LOAD:     p = PC_LOAD;
      default:      p = PC_IGNORE;
    endcase
    return p;
  endfunction

endpackage

[design/agfe_if.sv]
// agfe_if: valid/ready stream interfaces for input and result transactions
// depends on agfe_pkg for the payload types
interface agfe_in_if;
  logic               valid;
  logic               ready;
  agfe_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface agfe_out_if;
  logic                valid;
  logic                ready;
  agfe_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/agfe_datapath.sv]
// agfe_datapath: envelope state, fade slots, serial divider, multiplier, smoothing
// executes one control word per cycle while exec_i is high; depends on agfe_pkg
module agfe_datapath #(
  parameter int unsigned GAIN_BITS = agfe_pkg::GAIN_BITS_DEF,
  parameter int unsigned TIME_BITS = agfe_pkg::TIME_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  agfe_pkg::in_item_t  item_i,
  input  logic                exec_i,
  input  agfe_pkg::ctrl_t     ctrl_i,
  output agfe_pkg::status_t   status_o,
  output agfe_pkg::out_item_t result_o
);

  localparam int unsigned RB     = agfe_pkg::RATIO_BITS;
  localparam int unsigned PROD_W = GAIN_BITS + RB;
  localparam int unsigned CNT_W  = $clog2(RB);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [GAIN_BITS-1:0] gain_t;

  localparam gain_t GAIN_UNITY = {1'b1, {(GAIN_BITS-1){1'b0}}};

  function automatic time_t sat_add(time_t a, time_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  agfe_pkg::in_item_t item_q;

  // architectural state
  time_t time_q, total_q;
  gain_t tgt_q, cur_q;
  logic  fv_q [2];
  time_t fb_q [2];
  time_t fe_q [2];
  gain_t fs_q [2];
  logic  ft_q [2];
  gain_t fg_q [2];

  // working registers
  gain_t             g_q;
  time_t             rem_q, den_q;
  logic [RB-1:0]     quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PROD_W-1:0] prod_q;

  gain_t in_gain;
  time_t in_total, in_elapsed, in_dur;
  logic  sl;
  logic  started, reached, up;
  gain_t diff, prod_hi, interp;
  logic [TIME_BITS:0] shifted, sub;
  logic  take;
  gain_t sdiff, step, cur_next;
  logic [GAIN_BITS+1:0] s3;
  time_t fo_begin, fo_end;

  // input field conversion
  assign in_gain    = GAIN_BITS'(item_q.gain_value);
  assign in_total   = TIME_BITS'(item_q.total_us);
  assign in_elapsed = TIME_BITS'(item_q.elapsed_us);
  assign in_dur     = TIME_BITS'(item_q.duration_us);
  assign sl         = ctrl_i.slot;

  // fade slot window check
  assign started = fv_q[sl] && !(fb_q[sl] > time_q);
  assign reached = fe_q[sl] <= time_q;

  // interpolation between captured start and goal
  assign up      = fg_q[sl] >= fs_q[sl];
  assign diff    = up ? (fg_q[sl] - fs_q[sl]) : (fs_q[sl] - fg_q[sl]);
  assign prod_hi = prod_q[PROD_W-1:RB];
  assign interp  = up ? (fs_q[sl] + prod_hi) : (fs_q[sl] - prod_hi);

  // restoring divider step
  assign shifted = {rem_q, 1'b0};
  assign take    = shifted >= {1'b0, den_q};
  assign sub     = shifted - {1'b0, den_q};

  // one-pole smoothing, three quarters of the gap rounded half up
  assign sdiff = (g_q >= cur_q) ? (g_q - cur_q) : (cur_q - g_q);
  assign s3    = {2'b00, sdiff} + {1'b0, sdiff, 1'b0} + (GAIN_BITS+2)'(2);
  assign step  = s3[GAIN_BITS+1:2];
  assign cur_next = (g_q >= cur_q) ? (cur_q + step) : (cur_q - step);

  // fade-out window
  always_comb begin
    if (item_q.fade_now) begin
      fo_begin = time_q;
      fo_end   = sat_add(time_q, in_dur);
    end else begin
      fo_begin = (total_q >= in_dur) ? (total_q - in_dur) : '0;
      fo_end   = total_q;
    end
  end

  assign status_o.skip     = !started || reached;
  assign status_o.div_last = cnt_q == CNT_W'(RB - 1);

  assign result_o.current_gain = 16'(cur_q);
  assign result_o.target_gain  = 16'(tgt_q);
  assign result_o.fading       = fv_q[0] || fv_q[1];

  // architectural state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q  <= '0;
      total_q <= '0;
      tgt_q   <= '0;
      cur_q   <= '0;
      for (int k = 0; k < 2; k++) begin
        fv_q[k] <= 1'b0;
        fb_q[k] <= '0;
        fe_q[k] <= '0;
        fs_q[k] <= '0;
        ft_q[k] <= 1'b0;
        fg_q[k] <= '0;
      end
    end else if (exec_i) begin
      case (ctrl_i.op)
        agfe_pkg::OP_CHECK: begin
          if (started) begin
            if (reached) begin
              fv_q[sl] <= 1'b0;
            end else if (!ft_q[sl]) begin
              fs_q[sl] <= cur_q;
              ft_q[sl] <= 1'b1;
            end
          end
        end
        agfe_pkg::OP_FINISH: begin
          tgt_q  <= g_q;
          time_q <= sat_add(time_q, in_elapsed);
          cur_q  <= cur_next;
        end
        agfe_pkg::OP_SET: begin
          tgt_q <= in_gain;
        end
        agfe_pkg::OP_FADE_TO: begin
          fv_q[0] <= 1'b1;
          fb_q[0] <= time_q;
          fe_q[0] <= sat_add(time_q, in_dur);
          fs_q[0] <= '0;
          ft_q[0] <= 1'b0;
          fg_q[0] <= in_gain;
        end
        agfe_pkg::OP_FADE_OUT: begin
          fv_q[1] <= 1'b1;
          fb_q[1] <= fo_begin;
          fe_q[1] <= fo_end;
          fs_q[1] <= '0;
          ft_q[1] <= 1'b0;
          fg_q[1] <= '0;
        end
        agfe_pkg::OP_LOAD: begin
          time_q  <= '0;
          total_q <= in_total;
          tgt_q   <= '0;
          cur_q   <= '0;
          fv_q[0] <= 1'b1;
          fb_q[0] <= '0;
          fe_q[0] <= sat_add('0, in_dur);
          fs_q[0] <= '0;
          ft_q[0] <= 1'b0;
          fg_q[0] <= GAIN_UNITY;
          fv_q[1] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // working registers and transaction latch
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
    if (exec_i) begin
      case (ctrl_i.op)
        agfe_pkg::OP_BEGIN: begin
          g_q <= tgt_q;
        end
        agfe_pkg::OP_CHECK: begin
          if (started && reached) begin
            g_q <= fg_q[sl];
          end
          rem_q <= time_q - fb_q[sl];
          den_q <= fe_q[sl] - fb_q[sl];
          quo_q <= '0;
          cnt_q <= '0;
        end
        agfe_pkg::OP_DIV: begin
          rem_q <= take ? sub[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
          quo_q <= {quo_q[RB-2:0], take};
          cnt_q <= cnt_q + CNT_W'(1);
        end
        agfe_pkg::OP_MUL: begin
          prod_q <= PROD_W'(diff) * PROD_W'(quo_q);
        end
        agfe_pkg::OP_APPLY: begin
          g_q <= interp;
        end
        default: ;
      endcase
    end
  end

endmodule

[design/agfe_sequencer.sv]
// agfe_sequencer: step counter over the microcode rom with conditional jumps
// issues one control word per cycle to the datapath while running; depends on agfe_pkg
module agfe_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  agfe_pkg::pc_t     start_pc_i,
  input  agfe_pkg::status_t status_i,
  input  logic              out_free_i,
  output logic              idle_o,
  output logic              exec_o,
  output agfe_pkg::ctrl_t   ctrl_o,
  output logic              report_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_REPORT
  } state_e;

  state_e        state_q;
  agfe_pkg::pc_t pc_q;

  // control word fetch
  assign ctrl_o   = agfe_pkg::rom_word(pc_q);
  assign idle_o   = state_q == ST_IDLE;
  assign exec_o   = state_q == ST_RUN;
  assign report_o = (state_q == ST_REPORT) && out_free_i;

  // step counter and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            pc_q    <= start_pc_i;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          unique case (ctrl_o.br)
            agfe_pkg::BR_END: begin
              state_q <= ST_REPORT;
            end
            agfe_pkg::BR_LOOP: begin
              if (status_i.div_last) begin
                pc_q <= pc_q + agfe_pkg::pc_t'(1);
              end
            end
            agfe_pkg::BR_SKIP: begin
              pc_q <= status_i.skip ? ctrl_o.target : pc_q + agfe_pkg::pc_t'(1);
            end
            default: begin
              pc_q <= pc_q + agfe_pkg::pc_t'(1);
            end
          endcase
        end
        ST_REPORT: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[design/audio_gain_fade_envelope.sv]
// audio_gain_fade_envelope: gain envelope with linear fades and smoothing
// top level; depends on agfe_pkg, agfe_if, agfe_sequencer, agfe_datapath
//
//   channel  dir  modport  payload
//   in_i     in   sink     action, elapsed_us, gain_value, duration_us, fade_now, total_us
//   out_o    out  source   current_gain, target_gain, fading
//
// set, fade-to, fade-out, load and unknown actions each run a single control word
// a tick runs begin, then for each fade slot a check and, for a fade in mid-interpolation,
// a 16-step restoring divider for the ratio, a multiply and an apply, then finish
// reset clears all envelope state at once, no clearing pass
// the result sits in an output register, so the next transaction is taken while
// it waits; a stalled output only holds the sequencer at its report step
module audio_gain_fade_envelope #(
  parameter int unsigned GAIN_BITS = agfe_pkg::GAIN_BITS_DEF,
  parameter int unsigned TIME_BITS = agfe_pkg::TIME_BITS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  agfe_in_if.sink          in_i,
  agfe_out_if.source       out_o
);

  logic                start;
  logic                idle, exec, report, out_free;
  agfe_pkg::ctrl_t     ctrl;
  agfe_pkg::status_t   status;
  agfe_pkg::out_item_t result;
  logic                out_valid_q;
  agfe_pkg::out_item_t out_data_q;

  assign in_i.ready = idle;
  assign start      = in_i.valid && idle;
  assign out_free   = !out_valid_q || out_o.ready;

  agfe_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .start_pc_i (agfe_pkg::entry_pc(in_i.data.action)),
    .status_i   (status),
    .out_free_i (out_free),
    .idle_o     (idle),
    .exec_o     (exec),
    .ctrl_o     (ctrl),
    .report_o   (report)
  );

  agfe_datapath #(
    .GAIN_BITS (GAIN_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (start),
    .item_i   (in_i.data),
    .exec_i   (exec),
    .ctrl_i   (ctrl),
    .status_o (status),
    .result_o (result)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (report) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (report) begin
      out_data_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
